@@ rtl/pcs_pkg.sv @@
`timescale 1ns / 1ps

package pcs_pkg;

  localparam int GAP_DEPTH_DEF = 62;
  localparam int SQ_CELLS      = 25;
  localparam int ALPHA         = 26;

  localparam logic [7:0] CH_AU = 8'h41;  // 'A'
  localparam logic [7:0] CH_IU = 8'h49;  // 'I'
  localparam logic [7:0] CH_JU = 8'h4A;  // 'J'
  localparam logic [7:0] CH_QU = 8'h51;  // 'Q'
  localparam logic [7:0] CH_ZU = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_AL = 8'h61;  // 'a'
  localparam logic [7:0] CH_ZL = 8'h7A;  // 'z'
  localparam logic [7:0] CH_XL = 8'h78;  // 'x'
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [4:0] CODE_J = 5'd9;
  localparam logic [4:0] FILL_END = 5'd26;
  localparam logic [4:0] SQ_FULL = 5'd25;

  typedef enum logic [1:0] {
    KIND_KEY      = 2'd0,
    KIND_KEY_END  = 2'd1,
    KIND_TEXT     = 2'd2,
    KIND_TEXT_END = 2'd3
  } kind_e;

  typedef struct packed {
    logic load;
    logic key_char;
    logic fill_init;
    logic fill_step;
    logic buffer;
    logic set_pend;
    logic pair_text;
    logic pair_end;
    logic clear_text;
    logic pos_rd_a;
    logic pos_rd_b;
    logic cap_loc_a;
    logic cap_loc_b;
    logic sq_rd_a;
    logic sq_rd_b;
    logic cap_ca;
    logic cap_cb;
    logic push_in;
    logic push_ca;
    logic gap_rd;
    logic push_gap;
    logic push_cb;
  } pcs_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  letter;
    logic  pend_vld;
    logic  fill_done;
    logic  gap_done;
    logic  out_free;
  } pcs_sts_t;

  function automatic logic is_letter(input logic [7:0] ch);
    return ((ch >= CH_AL) && (ch <= CH_ZL)) || ((ch >= CH_AU) && (ch <= CH_ZU));
  endfunction

  // letter byte to 0..25, lowercase folded, J looked up as I
  function automatic logic [4:0] to_code(input logic [7:0] ch);
    logic [7:0] up;
    up = (ch >= CH_AL) ? (ch - CASE_OFS) : ch;
    if (up == CH_JU) begin
      up = CH_IU;
    end
    return 5'(up - CH_AU);
  endfunction

  function automatic logic [2:0] idx_row(input logic [4:0] idx);
    logic [2:0] r;
    if (idx >= 5'd20) begin
      r = 3'd4;
    end else if (idx >= 5'd15) begin
      r = 3'd3;
    end else if (idx >= 5'd10) begin
      r = 3'd2;
    end else if (idx >= 5'd5) begin
      r = 3'd1;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

  function automatic logic [2:0] idx_col(input logic [4:0] idx);
    logic [2:0] r;
    logic [4:0] base;
    r = idx_row(idx);
    base = ({2'b00, r} << 2) + {2'b00, r};
    return 3'(idx - base);
  endfunction

  // one step along a row or column, wrapping at five
  function automatic logic [2:0] step5(input logic [2:0] v, input logic back);
    logic [3:0] t;
    t = {1'b0, v} + (back ? 4'd4 : 4'd1);
    return (t >= 4'd5) ? 3'(t - 4'd5) : t[2:0];
  endfunction

  function automatic logic [4:0] rc_idx(input logic [2:0] r, input logic [2:0] c);
    return ({2'b00, r} << 2) + {2'b00, r} + {2'b00, c};
  endfunction

endpackage

@@ rtl/pcs_ctrl.sv @@
`timescale 1ns / 1ps

module pcs_ctrl
  import pcs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pcs_sts_t sts_i,
  output pcs_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FILL,
    ST_LOOK_A,
    ST_LOOK_B,
    ST_LOOK_C,
    ST_SQ_A,
    ST_SQ_B,
    ST_SQ_C,
    ST_EMIT_A,
    ST_DRAIN_RD,
    ST_DRAIN_WR,
    ST_EMIT_B
  } state_e;

  state_e state_q, state_d;
  logic   rdy_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && rdy_q) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts_i.kind)
          KIND_KEY: begin
            cmd_o.key_char = 1'b1;
            state_d        = ST_IDLE;
          end
          KIND_KEY_END: begin
            cmd_o.fill_init = 1'b1;
            state_d         = ST_FILL;
          end
          KIND_TEXT: begin
            if (!sts_i.letter && !sts_i.pend_vld) begin
              // pass straight through; hold until the output slot frees
              if (sts_i.out_free) begin
                cmd_o.push_in = 1'b1;
                state_d       = ST_IDLE;
              end
            end else if (!sts_i.letter) begin
              cmd_o.buffer = 1'b1;
              state_d      = ST_IDLE;
            end else if (!sts_i.pend_vld) begin
              cmd_o.set_pend = 1'b1;
              state_d        = ST_IDLE;
            end else begin
              cmd_o.pair_text = 1'b1;
              state_d         = ST_LOOK_A;
            end
          end
          KIND_TEXT_END: begin
            if (sts_i.pend_vld) begin
              cmd_o.pair_end = 1'b1;
              state_d        = ST_LOOK_A;
            end else begin
              cmd_o.clear_text = 1'b1;
              state_d          = ST_IDLE;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_FILL: begin
        if (sts_i.fill_done) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.fill_step = 1'b1;
        end
      end
      ST_LOOK_A: begin
        cmd_o.pos_rd_a = 1'b1;
        state_d        = ST_LOOK_B;
      end
      ST_LOOK_B: begin
        cmd_o.cap_loc_a = 1'b1;
        cmd_o.pos_rd_b  = 1'b1;
        state_d         = ST_LOOK_C;
      end
      ST_LOOK_C: begin
        cmd_o.cap_loc_b = 1'b1;
        state_d         = ST_SQ_A;
      end
      ST_SQ_A: begin
        cmd_o.sq_rd_a = 1'b1;
        state_d       = ST_SQ_B;
      end
      ST_SQ_B: begin
        cmd_o.cap_ca  = 1'b1;
        cmd_o.sq_rd_b = 1'b1;
        state_d       = ST_SQ_C;
      end
      ST_SQ_C: begin
        cmd_o.cap_cb = 1'b1;
        state_d      = ST_EMIT_A;
      end
      ST_EMIT_A: begin
        if (sts_i.out_free) begin
          cmd_o.push_ca = 1'b1;
          state_d       = ST_DRAIN_RD;
        end
      end
      ST_DRAIN_RD: begin
        if (sts_i.gap_done) begin
          state_d = ST_EMIT_B;
        end else begin
          cmd_o.gap_rd = 1'b1;
          state_d      = ST_DRAIN_WR;
        end
      end
      ST_DRAIN_WR: begin
        if (sts_i.out_free) begin
          cmd_o.push_gap = 1'b1;
          state_d        = ST_DRAIN_RD;
        end
      end
      ST_EMIT_B: begin
        if (sts_i.out_free) begin
          cmd_o.push_cb = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rdy_q   <= 1'b1;
    end else begin
      state_q <= state_d;
      rdy_q   <= (state_d == ST_IDLE);
    end
  end

  assign in_ready_o = rdy_q;

endmodule

@@ rtl/pcs_datapath.sv @@
`timescale 1ns / 1ps

module pcs_datapath
  import pcs_pkg::*;
#(
  parameter int GAP_DEPTH = GAP_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic [1:0] in_kind_i,
  input  logic [7:0] in_char_i,
  input  pcs_cmd_t   cmd_i,
  output pcs_sts_t   sts_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       out_last_o,
  output logic       out_lost_o
);

  localparam int GAP_AW = (GAP_DEPTH > 1) ? $clog2(GAP_DEPTH) : 1;
  localparam int GAP_CW = $clog2(GAP_DEPTH + 1);
  localparam logic [GAP_CW-1:0] GAP_MAX = GAP_CW'(GAP_DEPTH);

  // control state
  logic              mode_q;
  logic [ALPHA-1:0]  used_q;
  logic [4:0]        fill_q;
  logic [4:0]        fill_i_q;
  logic [7:0]        pend_q;
  logic              pend_vld_q;
  logic [GAP_CW-1:0] gap_cnt_q;
  logic [GAP_CW-1:0] drain_q;
  logic              lost_q;
  logic              out_vld_q;

  // payload
  kind_e      kind_q;
  logic [7:0] char_q;
  logic [7:0] a_q, b_q;
  logic [2:0] ar_q, ac_q, br_q, bc_q;
  logic [7:0] ca_q, cb_q;
  logic [4:0] pos_rd_q;
  logic       hit_q;
  logic [4:0] sq_rd_q;
  logic       ok_q;
  logic [7:0] gap_rd_q;
  logic [7:0] out_char_q;
  logic       out_last_q;
  logic       out_lost_q;

  // memories
  logic [4:0] sq_mem  [SQ_CELLS];
  logic [4:0] pos_mem [ALPHA];
  logic [7:0] gap_mem [GAP_DEPTH];

  logic [7:0] text_ch;
  logic       place_en;
  logic [4:0] place_code;
  logic [4:0] key_code;
  logic [4:0] pos_addr;
  logic [4:0] loc;
  logic [2:0] loc_row, loc_col;
  logic [4:0] idx_a, idx_b, sq_addr;
  logic [7:0] cell_base;
  logic       push;
  logic [7:0] push_char;
  logic       push_last;
  logic       out_free;

  // encryption folds uppercase text to lowercase
  always_comb begin
    text_ch = char_q;
    if (!mode_q && (char_q >= CH_AU) && (char_q <= CH_ZU)) begin
      text_ch = char_q + CASE_OFS;
    end
  end

  assign key_code = to_code(char_q);

  always_comb begin
    place_en   = 1'b0;
    place_code = key_code;
    if (cmd_i.key_char && is_letter(char_q)) begin
      place_en = !used_q[key_code] && (fill_q < SQ_FULL);
    end else if (cmd_i.fill_step) begin
      place_code = fill_i_q;
      place_en   = (fill_i_q != CODE_J) && !used_q[fill_i_q] && (fill_q < SQ_FULL);
    end
  end

  assign pos_addr = cmd_i.pos_rd_a ? to_code(a_q) : to_code(b_q);
  // a letter not yet placed sits at row 0, column 0
  assign loc      = hit_q ? pos_rd_q : 5'd0;
  assign loc_row  = idx_row(loc);
  assign loc_col  = idx_col(loc);

  always_comb begin
    if (ar_q == br_q) begin
      idx_a = rc_idx(ar_q, step5(ac_q, mode_q));
      idx_b = rc_idx(br_q, step5(bc_q, mode_q));
    end else if (ac_q == bc_q) begin
      idx_a = rc_idx(step5(ar_q, mode_q), ac_q);
      idx_b = rc_idx(step5(br_q, mode_q), bc_q);
    end else begin
      idx_a = rc_idx(ar_q, bc_q);
      idx_b = rc_idx(br_q, ac_q);
    end
  end

  assign sq_addr   = cmd_i.sq_rd_a ? idx_a : idx_b;
  assign cell_base = ok_q ? ({3'b000, sq_rd_q} + CH_AU) : 8'h00;

  assign out_free = !out_vld_q || out_ready_i;
  assign push     = cmd_i.push_in || cmd_i.push_ca || cmd_i.push_gap || cmd_i.push_cb;

  always_comb begin
    push_char = text_ch;
    push_last = 1'b1;
    if (cmd_i.push_ca) begin
      push_char = ca_q;
      push_last = 1'b0;
    end else if (cmd_i.push_gap) begin
      push_char = gap_rd_q;
      push_last = 1'b0;
    end else if (cmd_i.push_cb) begin
      push_char = cb_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      used_q     <= '0;
      fill_q     <= '0;
      fill_i_q   <= '0;
      pend_q     <= '0;
      pend_vld_q <= 1'b0;
      gap_cnt_q  <= '0;
      drain_q    <= '0;
      lost_q     <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (place_en) begin
        used_q[place_code] <= 1'b1;
        fill_q             <= fill_q + 5'd1;
      end
      if (cmd_i.fill_init) begin
        fill_i_q <= '0;
      end else if (cmd_i.fill_step) begin
        fill_i_q <= fill_i_q + 5'd1;
      end
      if (cmd_i.buffer) begin
        if (gap_cnt_q < GAP_MAX) begin
          gap_cnt_q <= gap_cnt_q + GAP_CW'(1);
        end else begin
          lost_q <= 1'b1;
        end
      end
      if (cmd_i.set_pend) begin
        pend_q     <= text_ch;
        pend_vld_q <= 1'b1;
      end
      // a doubled letter keeps its copy pending
      if (cmd_i.pair_text && !((text_ch == pend_q) && (text_ch != CH_XL))) begin
        pend_q     <= '0;
        pend_vld_q <= 1'b0;
      end
      if (cmd_i.pair_end || cmd_i.clear_text) begin
        pend_q     <= '0;
        pend_vld_q <= 1'b0;
      end
      if (cmd_i.clear_text || cmd_i.push_cb) begin
        gap_cnt_q <= '0;
      end
      if (cmd_i.push_ca) begin
        drain_q <= '0;
      end else if (cmd_i.gap_rd) begin
        drain_q <= drain_q + GAP_CW'(1);
      end
      if (push) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_e'(in_kind_i);
      char_q <= in_char_i;
    end
    if (cmd_i.pair_text) begin
      a_q <= pend_q;
      b_q <= ((text_ch == pend_q) && (text_ch != CH_XL)) ? CH_XL : text_ch;
    end else if (cmd_i.pair_end) begin
      a_q <= pend_q;
      b_q <= (pend_q == CH_QU) ? CH_XL : CH_QU;
    end
    if (cmd_i.cap_loc_a) begin
      ar_q <= loc_row;
      ac_q <= loc_col;
    end
    if (cmd_i.cap_loc_b) begin
      br_q <= loc_row;
      bc_q <= loc_col;
    end
    if (cmd_i.cap_ca) begin
      ca_q <= cell_base + ((a_q >= CH_AL) ? CASE_OFS : 8'h00);
    end
    if (cmd_i.cap_cb) begin
      cb_q <= cell_base + ((b_q >= CH_AL) ? CASE_OFS : 8'h00);
    end
    if (push) begin
      out_char_q <= push_char;
      out_last_q <= push_last;
      out_lost_q <= lost_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (place_en) begin
      sq_mem[fill_q]      <= place_code;
      pos_mem[place_code] <= fill_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pos_rd_a || cmd_i.pos_rd_b) begin
      pos_rd_q <= pos_mem[pos_addr];
      hit_q    <= used_q[pos_addr];
    end
    if (cmd_i.sq_rd_a || cmd_i.sq_rd_b) begin
      sq_rd_q <= sq_mem[sq_addr];
      ok_q    <= (sq_addr < fill_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.buffer && (gap_cnt_q < GAP_MAX)) begin
      gap_mem[gap_cnt_q[GAP_AW-1:0]] <= text_ch;
    end
    if (cmd_i.gap_rd) begin
      gap_rd_q <= gap_mem[drain_q[GAP_AW-1:0]];
    end
  end

  assign sts_o.kind      = kind_q;
  assign sts_o.letter    = is_letter(text_ch);
  assign sts_o.pend_vld  = pend_vld_q;
  assign sts_o.fill_done = (fill_q == SQ_FULL) || (fill_i_q == FILL_END);
  assign sts_o.gap_done  = (drain_q == gap_cnt_q);
  assign sts_o.out_free  = out_free;

  assign out_valid_o = out_vld_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;
  assign out_lost_o  = out_lost_q;

endmodule

@@ rtl/playfair_cipher_stream_core.sv @@
`timescale 1ns / 1ps

// Playfair stream engine. Send the key as key words (tuser 0), then one key-end word
// (tuser 1) to complete the 5x5 square, then text words (tuser 2) and a text-end word
// (tuser 3). cfg_wdata_i selects encrypt (0) or decrypt (1); write it only while idle.
// One word is taken at a time. A non-letter passed straight through waits out any output
// stall. A letter pair is worked by the controller stepping through the position memory,
// the square memory and the gap buffer one read at a time, and also waits out output
// stalls. Key end walks the alphabet one letter a cycle. Results leave through a
// one-word output register, and tlast marks the last word caused by an input word.
// tuser on the output is the sticky lost flag.
module playfair_cipher_stream_core
  import pcs_pkg::*;
#(
  parameter int GAP_DEPTH = GAP_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_char
  input  logic [1:0] s_axis_tuser,   // [1:0] kind
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tlast,
  output logic       m_axis_tuser    // [0] lost
);

  pcs_cmd_t cmd;
  pcs_sts_t sts;

  pcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pcs_datapath #(
    .GAP_DEPTH (GAP_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_kind_i   (s_axis_tuser),
    .in_char_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_lost_o  (m_axis_tuser)
  );

endmodule

@@ rtl/pcs_checker.sv @@
`timescale 1ns / 1ps

module pcs_checker
  import pcs_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [1:0] s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);

  // hold a stalled output word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // one word at a time: ready drops right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while previous word in progress");

  // key words emit nothing
  a_key_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid
    && (s_axis_tuser == KIND_KEY || s_axis_tuser == KIND_KEY_END) |=> !m_axis_tvalid)
    else $error("key word produced output");

  // lost flag never clears once shown
  a_lost_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tuser |=> !(m_axis_tvalid && !m_axis_tuser))
    else $error("lost flag cleared");

endmodule

bind playfair_cipher_stream_core pcs_checker u_pcs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

@@ verif/tb_playfair_cipher_stream_core.sv @@
`timescale 1ns / 1ps

module tb_playfair_cipher_stream_core;
  import pcs_pkg::*;

  localparam int GAP_SLOTS   = GAP_DEPTH_DEF;
  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 150;
  localparam int IDLE_CYCLES = 40;
  localparam logic [7:0] PAD_X = "x";
  localparam logic [7:0] PAD_Q = "Q";
  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_style_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       lost;
  } cipher_word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic       m_axis_tuser;

  playfair_cipher_stream_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  // cipher state as the block should hold it
  logic [4:0]   sq_code [SQ_CELLS];
  logic [25:0]  used_mask = '0;
  int           fill_cnt = 0;
  logic [7:0]   pend_ch = '0;
  logic         pend_vld = 1'b0;
  logic [7:0]   gap_mem [GAP_SLOTS];
  int           gap_cnt = 0;
  logic         lost_bit = 1'b0;
  logic         dec_mode = MODE_ENC;

  cipher_word_t cipher_out_q[$];
  cipher_word_t step_q[$];
  cipher_word_t exp_w;
  int           err_cnt = 0;
  int           burst_left = 0;
  int           quiet_cycles = 0;
  rx_style_e    rx_style = RX_OPEN;
  int           rx_hold = 0;
  logic [12:0]  rx_pat = 13'h1;

  function automatic bit alpha_byte(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic [7:0] any_nonletter();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (alpha_byte(c));
    return c;
  endfunction

  function automatic void place_code(input logic [7:0] up);
    int idx;
    idx = int'(up) - int'("A");
    if (used_mask[idx] || fill_cnt >= SQ_CELLS) begin
      return;
    end
    used_mask[idx] = 1'b1;
    sq_code[fill_cnt] = 5'(idx);
    fill_cnt++;
  endfunction

  // letter not found falls back to the top left cell
  function automatic void find_cell(input logic [7:0] c, output int r, output int col);
    logic [7:0] up;
    up = (c >= "a") ? c - 8'h20 : c;
    if (up == "J") begin
      up = "I";
    end
    r = 0;
    col = 0;
    for (int k = 0; k < fill_cnt; k++) begin
      if (int'(sq_code[k]) == int'(up) - int'("A")) begin
        r = k / 5;
        col = k % 5;
        return;
      end
    end
  endfunction

  function automatic logic [7:0] cell_byte(input int r, input int col, input logic [7:0] src);
    int idx;
    logic [7:0] v;
    idx = (r % 5) * 5 + (col % 5);
    v = (idx < fill_cnt) ? 8'(sq_code[idx]) + "A" : 8'h00;
    if (src >= "a") begin
      v = v + 8'h20;
    end
    return v;
  endfunction

  function automatic void emit_byte(input logic [7:0] c);
    cipher_word_t w;
    w.ch = c;
    w.last = 1'b0;
    w.lost = lost_bit;
    step_q.push_back(w);
  endfunction

  function automatic void emit_pair(input logic [7:0] a, input logic [7:0] b);
    int ar, ac, br, bc, shift;
    shift = dec_mode ? 4 : 1;
    find_cell(a, ar, ac);
    find_cell(b, br, bc);
    if (ar == br) begin
      emit_byte(cell_byte(ar, ac + shift, a));
      for (int k = 0; k < gap_cnt; k++) emit_byte(gap_mem[k]);
      emit_byte(cell_byte(br, bc + shift, b));
    end else if (ac == bc) begin
      emit_byte(cell_byte(ar + shift, ac, a));
      for (int k = 0; k < gap_cnt; k++) emit_byte(gap_mem[k]);
      emit_byte(cell_byte(br + shift, bc, b));
    end else begin
      emit_byte(cell_byte(ar, bc, a));
      for (int k = 0; k < gap_cnt; k++) emit_byte(gap_mem[k]);
      emit_byte(cell_byte(br, ac, b));
    end
    gap_cnt = 0;
  endfunction

  function automatic void playfair_step(input kind_e k, input logic [7:0] c);
    logic [7:0] ch;
    cipher_word_t w;
    ch = c;
    step_q.delete();
    case (k)
      KIND_KEY: begin
        if (ch >= "a" && ch <= "z") begin
          ch = ch - 8'h20;
        end
        if (ch >= "A" && ch <= "Z") begin
          if (ch == "J") begin
            ch = "I";
          end
          place_code(ch);
        end
      end
      KIND_KEY_END: begin
        for (int i = 0; i < 26; i++) begin
          if (i != int'("J") - int'("A")) begin
            place_code(8'(int'("A") + i));
          end
        end
      end
      KIND_TEXT: begin
        if (dec_mode == MODE_ENC && ch >= "A" && ch <= "Z") begin
          ch = ch + 8'h20;
        end
        if (!alpha_byte(ch)) begin
          if (!pend_vld) begin
            emit_byte(ch);
          end else if (gap_cnt < GAP_SLOTS) begin
            gap_mem[gap_cnt] = ch;
            gap_cnt++;
          end else begin
            lost_bit = 1'b1;
          end
        end else if (!pend_vld) begin
          pend_ch = ch;
          pend_vld = 1'b1;
        end else if (ch == pend_ch && ch != PAD_X) begin
          // doubled letter: pair with an inserted x, keep the second pending
          emit_pair(pend_ch, PAD_X);
          pend_ch = ch;
        end else begin
          emit_pair(pend_ch, ch);
          pend_vld = 1'b0;
          pend_ch = '0;
        end
      end
      default: begin
        if (pend_vld) begin
          emit_pair(pend_ch, (pend_ch == PAD_Q) ? PAD_X : PAD_Q);
        end
        pend_vld = 1'b0;
        pend_ch = '0;
        gap_cnt = 0;
      end
    endcase
    foreach (step_q[i]) begin
      w = step_q[i];
      w.last = (i == step_q.size() - 1);
      cipher_out_q.push_back(w);
    end
  endfunction

  function automatic void flag_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("%0t mismatch: %s", $realtime, msg);
    end
  endfunction

  // sender: bursts of random length, random gaps between them
  task automatic send_word(input kind_e k, input logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tuser <= k;
    do @(posedge clk_i); while (!s_axis_tready);
    playfair_step(k, c);
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_word(KIND_TEXT, s[i]);
  endtask

  task automatic send_key(input string s);
    foreach (s[i]) send_word(KIND_KEY, s[i]);
  endtask

  // hold off until every result is back and the block has gone quiet
  task automatic drain_words();
    s_axis_tvalid <= 1'b0;
    while (cipher_out_q.size() != 0) @(posedge clk_i);
    repeat (IDLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    drain_words();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dec_mode = m;
  endtask

  // square: P L A Y F / I R E X M / B C D G H / K N O Q S / T U V W Z
  task automatic test_key_schedule();
    write_mode(MODE_ENC);
    send_key("pLaYFjR");
    send_word(KIND_KEY, 8'hFF);
    send_key("exMA");
    send_word(KIND_KEY, 8'h00);
    send_word(KIND_KEY_END, 8'h00);
    // square is full: both of these change nothing
    send_word(KIND_KEY, "Z");
    send_word(KIND_KEY_END, 8'hFF);
  endtask

  task automatic test_encrypt_cases();
    write_mode(MODE_ENC);
    send_word(KIND_TEXT, 8'h00);
    // pass-through, row pair, j looked up as I with a buffered comma, doubled e,
    // x after x kept as a pair, odd letter padded with Q around a buffered byte
    send_text("#PLj,Ieewxxz");
    send_word(KIND_TEXT, 8'h80);
    send_word(KIND_TEXT_END, 8'h00);
    send_word(KIND_TEXT_END, 8'hFF);
  endtask

  task automatic test_decrypt_cases();
    write_mode(MODE_DEC);
    // pending Q pads with x; doubled uppercase X; backward row shift and column wrap
    send_text("Q");
    send_word(KIND_TEXT_END, 8'h00);
    send_text("XXtYFTPaA");
    send_word(KIND_TEXT_END, 8'h00);
  endtask

  task automatic test_random_stream();
    int sent;
    int pick;
    logic [7:0] ch;
    logic [7:0] prev;
    prev = "a";
    for (int phase = 0; phase < 4; phase++) begin
      write_mode(phase[0]);
      sent = 0;
      while (sent < 58) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          if ($urandom_range(0, 9) == 0) begin
            ch = prev;
          end else if ($urandom_range(0, 19) == 0) begin
            ch = $urandom_range(0, 1) ? "x" : "X";
          end else begin
            ch = 8'($urandom_range(0, 25)) + "a";
            if ($urandom_range(0, 1)) ch = ch - 8'h20;
          end
          prev = ch;
          send_word(KIND_TEXT, ch);
          sent++;
        end else if (pick < 85) begin
          send_word(KIND_TEXT, any_nonletter());
          sent++;
        end else if (pick < 92) begin
          send_word(KIND_TEXT, 8'($urandom_range(0, 255)));
          sent++;
        end else if (pick < 97) begin
          send_word(KIND_TEXT_END, 8'($urandom_range(0, 255)));
          sent++;
        end else if (pick < 99) begin
          send_word(KIND_KEY, 8'($urandom_range(0, 255)));
        end else begin
          send_word(KIND_KEY_END, 8'($urandom_range(0, 255)));
        end
      end
      send_word(KIND_TEXT_END, 8'h00);
    end
  endtask

  // fill the gap buffer, drop one more, and check the flag stays set
  task automatic test_gap_overflow();
    write_mode(1'($urandom_range(0, 1)));
    send_text("c");
    repeat (GAP_SLOTS + 1) send_word(KIND_TEXT, any_nonletter());
    send_text("D!h");
    send_word(KIND_TEXT_END, 8'h00);
  endtask

  // receiver stall pattern, picked anew at random when its hold runs out
  always @(posedge clk_i) begin
    if (rx_hold == 0) begin
      rx_style = rx_style_e'($urandom_range(0, 3));
      rx_hold = $urandom_range(16, 96);
      rx_pat = 13'($urandom) | 13'h1;
    end
    rx_hold--;
    case (rx_style)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: begin
        m_axis_tready <= rx_pat[0];
        rx_pat = {rx_pat[0], rx_pat[12:1]};
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (cipher_out_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected word char %h last %b lost %b",
                                m_axis_tdata, m_axis_tlast, m_axis_tuser));
      end else begin
        exp_w = cipher_out_q.pop_front();
        if (exp_w.ch !== m_axis_tdata) begin
          flag_mismatch($sformatf("char exp %h got %h", exp_w.ch, m_axis_tdata));
        end
        if (exp_w.last !== m_axis_tlast) begin
          flag_mismatch($sformatf("last exp %b got %b (char %h)",
                                  exp_w.last, m_axis_tlast, exp_w.ch));
        end
        if (exp_w.lost !== m_axis_tuser) begin
          flag_mismatch($sformatf("lost exp %b got %b (char %h)",
                                  exp_w.lost, m_axis_tuser, exp_w.ch));
        end
      end
    end
  end

  // watchdog: give up after too long with no word moving on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_key_schedule();
    test_encrypt_cases();
    test_decrypt_cases();
    test_random_stream();
    test_gap_overflow();
    drain_words();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && cipher_out_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pcs_pkg.sv
rtl/pcs_ctrl.sv
rtl/pcs_datapath.sv
rtl/playfair_cipher_stream_core.sv
rtl/pcs_checker.sv
verif/tb_playfair_cipher_stream_core.sv
